// ===== rtl/tuning_command_frame_parser_unit_macros.svh =====
// Assertion macros used by the command frame parser RTL.
`ifndef TUNING_COMMAND_FRAME_PARSER_UNIT_MACROS_SVH
`define TUNING_COMMAND_FRAME_PARSER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off during rst.
`define TCFP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, sampled on clk, off during rst.
`define TCFP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TCFP_ASSERT_IMP(label, ante, cons, msg)
`define TCFP_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

// ===== rtl/tcfp_pkg.sv =====
// Types, character codes and decode functions for the command frame parser.
`default_nettype none
package tcfp_pkg;

  localparam int FrameLenDefault = 10;
  localparam int HdrLen          = 8;
  localparam int HdrAw           = $clog2(HdrLen);

  localparam logic [7:0] ChBang  = 8'h21;  // '!'
  localparam logic [7:0] ChHash  = 8'h23;  // '#'
  localparam logic [7:0] ChAt    = 8'h40;  // '@'
  localparam logic [7:0] ChEq    = 8'h3D;  // '='
  localparam logic [7:0] ChP     = 8'h50;
  localparam logic [7:0] ChA     = 8'h41;
  localparam logic [7:0] ChD     = 8'h44;
  localparam logic [7:0] ChDl    = 8'h64;  // 'd'
  localparam logic [7:0] ChL     = 8'h4C;
  localparam logic [7:0] ChI     = 8'h49;
  localparam logic [7:0] ChR     = 8'h52;
  localparam logic [7:0] ChIl    = 8'h69;  // 'i'
  localparam logic [7:0] ChOne   = 8'h31;
  localparam logic [7:0] ChTwo   = 8'h32;
  localparam logic [7:0] ChThree = 8'h33;

  typedef enum logic [3:0] {
    GAIN_NONE = 4'd0,
    GAIN_P    = 4'd1,
    GAIN_A    = 4'd2,
    GAIN_D    = 4'd3,
    GAIN_DL   = 4'd4,
    GAIN_L    = 4'd5,
    GAIN_I    = 4'd6,
    GAIN_R    = 4'd7,
    GAIN_IL   = 4'd8
  } gain_t;

  typedef enum logic [1:0] {
    OP_NONE     = 2'd0,
    OP_ASSIGN   = 2'd1,
    OP_INCREASE = 2'd2,
    OP_DECREASE = 2'd3
  } op_t;

  typedef struct packed {
    logic       vld;
    logic [7:0] data;
  } byte_stage_t;

  typedef struct packed {
    logic        frame_valid;
    logic [3:0]  gain_select;
    logic [1:0]  operation;
    logic [31:0] value_bits;
  } result_t;

  typedef struct packed {
    logic taken;
    logic push;
  } core_ctl_t;

  function automatic gain_t decode_gain(input logic [7:0] c);
    gain_t g;
    case (c)
      ChP:     g = GAIN_P;
      ChA:     g = GAIN_A;
      ChD:     g = GAIN_D;
      ChDl:    g = GAIN_DL;
      ChL:     g = GAIN_L;
      ChI:     g = GAIN_I;
      ChR:     g = GAIN_R;
      ChIl:    g = GAIN_IL;
      default: g = GAIN_NONE;
    endcase
    return g;
  endfunction

  function automatic op_t decode_op(input logic [7:0] c);
    op_t o;
    case (c)
      ChOne:   o = OP_ASSIGN;
      ChTwo:   o = OP_INCREASE;
      ChThree: o = OP_DECREASE;
      default: o = OP_NONE;
    endcase
    return o;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/tcfp_byte_if.sv =====
// Valid/ready channel carrying one received serial byte per word.
`default_nettype none
interface tcfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

// ===== rtl/tcfp_result_if.sv =====
// Valid/ready channel carrying one decoded command frame per word.
`default_nettype none
interface tcfp_result_if;
  logic        valid;
  logic        ready;
  logic        frame_valid;
  logic [3:0]  gain_select;
  logic [1:0]  operation;
  logic [31:0] value_bits;

  modport source (
    output valid, output frame_valid, output gain_select, output operation,
    output value_bits, input ready
  );
  modport sink (
    input valid, input frame_valid, input gain_select, input operation,
    input value_bits, output ready
  );
endinterface
`default_nettype wire

// ===== rtl/tcfp_in_stage.sv =====
// Input register holding the next received byte for the frame core.
`default_nettype none
module tcfp_in_stage
  import tcfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  tcfp_byte_if.sink   rx,
  input  logic        taken,
  output byte_stage_t stage
);

  byte_stage_t stage_q;

  assign rx.ready = !stage_q.vld || taken;
  assign stage    = stage_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_q.vld <= 1'b0;
    end else if (rx.valid && rx.ready) begin
      stage_q.vld <= 1'b1;
    end else if (taken) begin
      stage_q.vld <= 1'b0;
    end
    if (rx.valid && rx.ready) begin
      stage_q.data <= rx.rx_byte;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/tcfp_frame_core.sv =====
// Frame buffer, write index and combinational frame check and decode.
`default_nettype none
`include "tuning_command_frame_parser_unit_macros.svh"
module tcfp_frame_core
  import tcfp_pkg::*;
#(
  parameter int FRAME_LEN = FrameLenDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  byte_stage_t stage,
  input  logic        out_free,
  output core_ctl_t   ctl,
  output result_t     res
);

  localparam int IdxW = $clog2(FRAME_LEN + 1);

  logic [IdxW-1:0] write_index;
  logic [IdxW-1:0] write_index_next;
  logic            prev_bang;
  logic            prev_bang_next;
  logic [7:0]      hdr [HdrLen];
  logic [7:0]      eff [HdrLen];

  logic at_full;
  logic complete;
  logic step;
  logic hdr_wr;
  logic good;

  assign at_full  = write_index == IdxW'(FRAME_LEN);
  assign complete = stage.vld && !at_full && (write_index != '0) && prev_bang &&
                    (stage.data == ChHash);
  assign step     = stage.vld && (!complete || out_free);
  assign hdr_wr   = step && (write_index < IdxW'(HdrLen));

  assign ctl.taken = step;
  assign ctl.push  = complete && out_free;

  // Header bytes as they stand once the current byte is stored.
  always_comb begin
    for (int k = 0; k < HdrLen; k++) begin
      eff[k] = (write_index == IdxW'(k)) ? stage.data : hdr[k];
    end
  end

  assign good = (write_index == IdxW'(FRAME_LEN - 1)) && (eff[0] == ChAt) &&
                (eff[3] == ChEq);

  always_comb begin
    res.frame_valid = good;
    res.gain_select = good ? decode_gain(eff[1]) : GAIN_NONE;
    res.operation   = good ? decode_op(eff[2]) : OP_NONE;
    res.value_bits  = good ? {eff[7], eff[6], eff[5], eff[4]} : 32'd0;
  end

  always_comb begin
    write_index_next = write_index;
    prev_bang_next   = prev_bang;
    if (step) begin
      if (at_full || complete) begin
        write_index_next = '0;
        prev_bang_next   = 1'b0;
      end else begin
        write_index_next = write_index + 1'b1;
        prev_bang_next   = stage.data == ChBang;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_index <= '0;
      prev_bang   <= 1'b0;
    end else begin
      write_index <= write_index_next;
      prev_bang   <= prev_bang_next;
    end
  end

  always_ff @(posedge clk) begin
    if (hdr_wr) begin
      hdr[write_index[HdrAw-1:0]] <= stage.data;
    end
  end

  `TCFP_ASSERT_IMP(a_index_range, 1'b1, write_index <= IdxW'(FRAME_LEN), "index past full")
  `TCFP_ASSERT_NXT(a_push_clears, ctl.push, write_index == '0 && !prev_bang, "no clear")
  `TCFP_ASSERT_IMP(a_push_room, ctl.push, out_free && ctl.taken, "push without room")
  `TCFP_ASSERT_IMP(a_bad_zero, ctl.push && !res.frame_valid,
                   res.gain_select == GAIN_NONE && res.operation == OP_NONE &&
                   res.value_bits == 32'd0, "bad frame fields")

endmodule
`default_nettype wire

// ===== rtl/tcfp_out_stage.sv =====
// Result register presenting decoded frames to the downstream sink.
`default_nettype none
module tcfp_out_stage
  import tcfp_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  result_t       res,
  output logic          out_free,
  tcfp_result_if.source cmd
);

  logic    vld;
  result_t res_q;

  assign out_free        = !vld || cmd.ready;
  assign cmd.valid       = vld;
  assign cmd.frame_valid = res_q.frame_valid;
  assign cmd.gain_select = res_q.gain_select;
  assign cmd.operation   = res_q.operation;
  assign cmd.value_bits  = res_q.value_bits;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (push) begin
      vld <= 1'b1;
    end else if (cmd.ready) begin
      vld <= 1'b0;
    end
    if (push) begin
      res_q <= res;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/tuning_command_frame_parser_unit.sv =====
// Top level of the fixed-length ASCII tuning command frame parser.
// Accepts one byte word per cycle. Each byte passes an input register, then
// the frame core checks and decodes it combinationally, and the decoded frame
// word is held in a result register, from which it is presented downstream.
// Intake stalls only while a finished frame waits in a full result register.
// Frames are FRAME_LEN bytes: '@', gain letter, operation digit, '=',
// four value bytes (first one lowest), then '!' and '#'. A byte arriving when
// the buffer is already full is dropped and restarts the frame.
`default_nettype none
module tuning_command_frame_parser_unit
  import tcfp_pkg::*;
#(
  parameter int FRAME_LEN = FrameLenDefault
) (
  input  logic          clk,
  input  logic          rst,
  tcfp_byte_if.sink     rx,
  tcfp_result_if.source cmd
);

  byte_stage_t stage;
  core_ctl_t   ctl;
  result_t     res;
  logic        out_free;

  tcfp_in_stage u_in (
    .clk   (clk),
    .rst   (rst),
    .rx    (rx),
    .taken (ctl.taken),
    .stage (stage)
  );

  tcfp_frame_core #(
    .FRAME_LEN (FRAME_LEN)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .stage    (stage),
    .out_free (out_free),
    .ctl      (ctl),
    .res      (res)
  );

  tcfp_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .push     (ctl.push),
    .res      (res),
    .out_free (out_free),
    .cmd      (cmd)
  );

endmodule
`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for the command frame parser: directed, then random bytes.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tcfp_pkg::*;

  localparam int FrameLen  = 10;
  localparam int ByteCount = 1100;
  localparam int QuietFrom = 850;

  typedef struct packed {
    logic [95:0] seq;
    logic [3:0]  len;
    logic        typed;
    logic        fires;
    result_t     res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tcfp_byte_if   rx_bus ();
  tcfp_result_if cmd_bus ();

  tuning_command_frame_parser_unit #(.FRAME_LEN(FrameLen)) dut (
    .clk(clk),
    .rst(rst),
    .rx (rx_bus),
    .cmd(cmd_bus)
  );

  logic [7:0]  rx_frame [FrameLen];
  int unsigned rx_pos;
  result_t     pending_cmds [$];
  bit          failed = 1'b0;
  bit          idle_on = 1'b1;
  int unsigned bytes_sent = 0;
  int unsigned stall_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void reset_frame();
    foreach (rx_frame[i]) rx_frame[i] = 8'h00;
    rx_pos = 0;
  endfunction

  // Returns 1 when the byte closes a frame; r then holds the command word.
  function automatic bit parse_byte(input logic [7:0] b, output result_t r);
    r = '0;
    if (rx_pos >= FrameLen) begin
      reset_frame();
      return 1'b0;
    end
    rx_frame[rx_pos] = b;
    if (rx_pos == 0 || rx_frame[rx_pos-1] != ChBang || b != ChHash) begin
      rx_pos++;
      return 1'b0;
    end
    if (rx_frame[0] == ChAt && rx_frame[3] == ChEq &&
        rx_frame[FrameLen-2] == ChBang && rx_frame[FrameLen-1] == ChHash) begin
      r.frame_valid = 1'b1;
      case (rx_frame[1])
        ChP:     r.gain_select = GAIN_P;
        ChA:     r.gain_select = GAIN_A;
        ChD:     r.gain_select = GAIN_D;
        ChDl:    r.gain_select = GAIN_DL;
        ChL:     r.gain_select = GAIN_L;
        ChI:     r.gain_select = GAIN_I;
        ChR:     r.gain_select = GAIN_R;
        ChIl:    r.gain_select = GAIN_IL;
        default: r.gain_select = GAIN_NONE;
      endcase
      case (rx_frame[2])
        ChOne:   r.operation = OP_ASSIGN;
        ChTwo:   r.operation = OP_INCREASE;
        ChThree: r.operation = OP_DECREASE;
        default: r.operation = OP_NONE;
      endcase
      r.value_bits = {rx_frame[7], rx_frame[6], rx_frame[5], rx_frame[4]};
    end
    reset_frame();
    return 1'b1;
  endfunction

  task automatic put_byte(input logic [7:0] b, output bit fired, output result_t r);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      rx_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    rx_bus.valid   <= 1'b1;
    rx_bus.rx_byte <= b;
    do @(posedge clk); while (!rx_bus.ready);
    fired = parse_byte(b, r);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_predicted(input logic [7:0] b);
    bit      fired;
    result_t r;
    put_byte(b, fired, r);
    if (fired) pending_cmds.push_back(r);
  endtask

  // One random unit: mostly well-formed frames, plus corrupted, short,
  // overlong frames and plain noise.
  task automatic send_random_unit();
    logic [7:0] f [$];
    int         kind;
    int         pos;
    logic [7:0] v;
    kind = $urandom_range(0, 9);
    if (kind == 7) begin
      repeat ($urandom_range(0, 6)) f.push_back(8'($urandom_range(0, 255)));
      f.push_back(ChBang);
      f.push_back(ChHash);
    end else if (kind == 8) begin
      repeat ($urandom_range(1, 14)) f.push_back(8'($urandom_range(0, 255)));
    end else begin
      f.push_back(ChAt);
      case ($urandom_range(0, 8))
        0:       v = ChP;
        1:       v = ChA;
        2:       v = ChD;
        3:       v = ChDl;
        4:       v = ChL;
        5:       v = ChI;
        6:       v = ChR;
        7:       v = ChIl;
        default: v = 8'($urandom_range(0, 255));
      endcase
      f.push_back(v);
      if ($urandom_range(0, 5) == 0) v = 8'($urandom_range(0, 255));
      else v = ChOne + 8'($urandom_range(0, 2));
      f.push_back(v);
      f.push_back(ChEq);
      repeat (4) begin
        case ($urandom_range(0, 7))
          0:       v = 8'h00;
          1:       v = 8'hFF;
          default: v = 8'($urandom_range(0, 255));
        endcase
        f.push_back(v);
      end
      if (kind == 9) repeat ($urandom_range(1, 4)) f.push_back(8'($urandom_range(0, 255)));
      f.push_back(ChBang);
      f.push_back(ChHash);
      if (kind == 6) begin
        pos = $urandom_range(0, f.size() - 1);
        f[pos] = 8'($urandom_range(0, 255));
      end
    end
    foreach (f[i]) send_predicted(f[i]);
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      cmd_bus.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 9);
      cmd_bus.ready <= 1'b0;
    end else begin
      cmd_bus.ready <= 1'b1;
    end
  end

  // one command word per completed frame
  always @(posedge clk) begin : cmd_check
    result_t want;
    if (!rst && cmd_bus.valid && cmd_bus.ready) begin
      if (pending_cmds.size() == 0) begin
        failed = 1'b1;
        $display("%0t: unexpected word: expected none, got fv=%0b gain=%0d op=%0d value=%h",
                 $time, cmd_bus.frame_valid, cmd_bus.gain_select, cmd_bus.operation,
                 cmd_bus.value_bits);
      end else begin
        want = pending_cmds.pop_front();
        if (cmd_bus.frame_valid !== want.frame_valid) begin
          failed = 1'b1;
          $display("%0t: frame_valid expected %0b got %0b", $time, want.frame_valid,
                   cmd_bus.frame_valid);
        end
        if (cmd_bus.gain_select !== want.gain_select) begin
          failed = 1'b1;
          $display("%0t: gain_select expected %0d got %0d", $time, want.gain_select,
                   cmd_bus.gain_select);
        end
        if (cmd_bus.operation !== want.operation) begin
          failed = 1'b1;
          $display("%0t: operation expected %0d got %0d", $time, want.operation,
                   cmd_bus.operation);
        end
        if (cmd_bus.value_bits !== want.value_bits) begin
          failed = 1'b1;
          $display("%0t: value_bits expected %h got %h", $time, want.value_bits,
                   cmd_bus.value_bits);
        end
      end
    end
  end

  initial begin
    dir_row_t   rows [5];
    bit         fired;
    result_t    r;
    logic [7:0] b;
    rx_bus.valid   = 1'b0;
    rx_bus.rx_byte = 8'h00;
    cmd_bus.ready  = 1'b0;
    reset_frame();

    // P assign, value all zeros
    rows[0] = {ChAt, ChP, ChOne, ChEq, 32'h0000_0000, ChBang, ChHash, 16'h0,
               4'd10, 1'b1, 1'b1, 1'b1, GAIN_P, OP_ASSIGN, 32'h0000_0000};
    // '#' first is stored, then a short frame closes: invalid, all zeros
    rows[1] = {ChHash, ChBang, ChHash, 72'h0,
               4'd3, 1'b1, 1'b1, 1'b0, GAIN_NONE, OP_NONE, 32'h0000_0000};
    // i decrease, value all ones
    rows[2] = {ChAt, ChIl, ChThree, ChEq, 32'hFFFF_FFFF, ChBang, ChHash, 16'h0,
               4'd10, 1'b1, 1'b1, 1'b1, GAIN_IL, OP_DECREASE, 32'hFFFF_FFFF};
    // unknown gain letter with increase
    rows[3] = {ChAt, 8'h3F, ChTwo, ChEq, 8'h78, 8'h56, 8'h34, 8'h12, ChBang, ChHash, 16'h0,
               4'd10, 1'b0, 1'b0, 1'b0, GAIN_NONE, OP_NONE, 32'h0};
    // buffer fills with no close; the '#' after it is dropped, no word
    rows[4] = {ChAt, ChP, ChOne, ChEq, 8'h01, 8'h02, 8'h03, 8'h04, ChBang, ChBang, ChHash,
               8'h0, 4'd11, 1'b1, 1'b0, 1'b0, GAIN_NONE, OP_NONE, 32'h0};

    repeat (4) @(negedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      for (int k = 0; k < rows[i].len; k++) begin
        b = rows[i].seq[95-8*k -: 8];
        put_byte(b, fired, r);
        if (rows[i].typed) begin
          if (k == rows[i].len - 1 && rows[i].fires) pending_cmds.push_back(rows[i].res);
        end else if (fired) begin
          pending_cmds.push_back(r);
        end
      end
    end

    while (bytes_sent < ByteCount) begin
      idle_on = (bytes_sent < QuietFrom) && ((bytes_sent / 200) % 3 != 2);
      send_random_unit();
    end
    idle_on = 1'b0;
    rx_bus.valid <= 1'b0;

    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (!failed && pending_cmds.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
